### rtl/u8dec_pkg.sv
`default_nettype none
package u8dec_pkg;

	localparam int unsigned CpWidth    = 21;
	localparam int unsigned CountWidth = 16;

	typedef logic [7:0]            unit_t;
	typedef logic [CpWidth-1:0]    cp_t;
	typedef logic [CountWidth-1:0] count_t;
	typedef logic [1:0]            pend_t;

	localparam count_t CapReset = 16'hFFFF;

	// Lead byte class boundaries and payload masks
	localparam unit_t LeadTwo   = 8'h80;
	localparam unit_t LeadThree = 8'hE0;
	localparam unit_t LeadFour  = 8'hF0;
	localparam unit_t MaskTwo   = 8'h1F;
	localparam unit_t MaskThree = 8'h0F;
	localparam unit_t MaskFour  = 8'h07;
	localparam unit_t MaskCont  = 8'h3F;

	// Continuation bytes still expected
	localparam pend_t PendNone  = 2'd0;
	localparam pend_t PendOne   = 2'd1;
	localparam pend_t PendTwo   = 2'd2;
	localparam pend_t PendThree = 2'd3;

endpackage
`default_nettype wire

### rtl/u8dec_if.sv
`default_nettype none
interface u8dec_in_if;
	logic            valid;
	logic            ready;
	u8dec_pkg::unit_t in_byte;
	logic            string_end;

	modport source (output valid, output in_byte, output string_end, input ready);
	modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface u8dec_out_if;
	logic              valid;
	logic              ready;
	u8dec_pkg::cp_t    decoded;
	logic              point_valid;
	u8dec_pkg::count_t written_count;
	logic              string_done;

	modport source (output valid, output decoded, output point_valid,
		output written_count, output string_done, input ready);
	modport sink   (input valid, input decoded, input point_valid,
		input written_count, input string_done, output ready);
endinterface
`default_nettype wire

### rtl/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder: one byte in, at most one code point out.
// Channels: units (sink) carries in_byte and string_end, one byte per beat;
// points (source) carries decoded, point_valid, written_count and
// string_done. Both use valid/ready; a beat moves when both are high.
// cfg_we/cfg_wdata load the per-string capacity; write it only while idle.
// A byte that yields a result shows it on points in the cycle after its
// beat is accepted. Throughput: one byte per cycle unless points stalls,
// set by the single decode step between decoder state and result registers.
// Bytes that only open or extend a sequence, and points dropped at capacity,
// produce no beat. The string_end byte always produces exactly one beat
// with string_done high, then all per-string state returns to zero.
// Reset: decoder state and counters clear, the capacity returns to 65535,
// and the result register empties.
// Stall: while points is stalled with a result held, units stays ready
// only in the cycle the held beat leaves; otherwise input is held off and
// no beat is lost or repeated.
`default_nettype none
module utf8_stream_decoder_unit (
	input  wire                    clk,
	input  wire                    arst_n,
	u8dec_in_if.sink               units,
	u8dec_out_if.source            points,
	input  wire                    cfg_we,
	input  wire u8dec_pkg::count_t cfg_wdata
);

	// decoder state
	u8dec_pkg::cp_t    partial_q;
	u8dec_pkg::pend_t  pending_q;
	u8dec_pkg::count_t count_q;
	u8dec_pkg::count_t cap_q;

	// result register
	logic              res_valid_q;
	u8dec_pkg::cp_t    res_cp_q;
	logic              res_pv_q;
	u8dec_pkg::count_t res_cnt_q;
	logic              res_done_q;

	logic              take;
	u8dec_pkg::unit_t  b;
	u8dec_pkg::cp_t    cont_bits;
	u8dec_pkg::cp_t    partial_d;
	u8dec_pkg::pend_t  pending_d;
	logic              finished;
	logic              written;
	logic              emit;
	u8dec_pkg::count_t count_inc;

	// Accept a byte whenever the result register is empty or draining.
	assign units.ready = !res_valid_q || points.ready;
	assign take        = units.valid && units.ready;
	assign b           = units.in_byte;
	assign count_inc   = count_q + u8dec_pkg::count_t'(1);

	// Place the continuation payload at its bit slot.
	always_comb begin
		cont_bits = '0;
		case (pending_q)
			u8dec_pkg::PendOne:   cont_bits = u8dec_pkg::cp_t'(b & u8dec_pkg::MaskCont);
			u8dec_pkg::PendTwo:   cont_bits = u8dec_pkg::cp_t'(b & u8dec_pkg::MaskCont) << 6;
			u8dec_pkg::PendThree: cont_bits = u8dec_pkg::cp_t'(b & u8dec_pkg::MaskCont) << 12;
			default:              cont_bits = '0;
		endcase
	end

	// Decode one byte against the current sequence state.
	always_comb begin
		finished  = 1'b0;
		partial_d = partial_q;
		pending_d = pending_q;
		if (pending_q == u8dec_pkg::PendNone) begin
			if (b < u8dec_pkg::LeadTwo) begin
				partial_d = u8dec_pkg::cp_t'(b);
				finished  = 1'b1;
			end else if (b < u8dec_pkg::LeadThree) begin
				partial_d = u8dec_pkg::cp_t'(b & u8dec_pkg::MaskTwo) << 6;
				pending_d = u8dec_pkg::PendOne;
			end else if (b < u8dec_pkg::LeadFour) begin
				partial_d = u8dec_pkg::cp_t'(b & u8dec_pkg::MaskThree) << 12;
				pending_d = u8dec_pkg::PendTwo;
			end else begin
				partial_d = u8dec_pkg::cp_t'(b & u8dec_pkg::MaskFour) << 18;
				pending_d = u8dec_pkg::PendThree;
			end
		end else begin
			partial_d = partial_q | cont_bits;
			pending_d = pending_q - u8dec_pkg::pend_t'(1);
			finished  = (pending_d == u8dec_pkg::PendNone);
		end
		// Close a cut-off sequence at string end with zero bits.
		if (units.string_end && pending_d != u8dec_pkg::PendNone) begin
			pending_d = u8dec_pkg::PendNone;
			finished  = 1'b1;
		end
		written = finished && (count_q < cap_q);
		emit    = written || units.string_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			pending_q   <= u8dec_pkg::PendNone;
			count_q     <= '0;
			cap_q       <= u8dec_pkg::CapReset;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (take) begin
				if (units.string_end) begin
					partial_q <= '0;
					pending_q <= u8dec_pkg::PendNone;
					count_q   <= '0;
				end else begin
					partial_q <= finished ? '0 : partial_d;
					pending_q <= pending_d;
					if (written) begin
						count_q <= count_inc;
					end
				end
				res_valid_q <= emit;
			end else if (points.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: load only with a beat that produces one.
	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_cp_q   <= written ? partial_d : '0;
			res_pv_q   <= written;
			res_cnt_q  <= written ? count_inc : count_q;
			res_done_q <= units.string_end;
		end
	end

	assign points.valid         = res_valid_q;
	assign points.decoded       = res_cp_q;
	assign points.point_valid   = res_pv_q;
	assign points.written_count = res_cnt_q;
	assign points.string_done   = res_done_q;

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none
module testbench;

	typedef struct packed {
		u8dec_pkg::cp_t    decoded;
		logic              point_valid;
		u8dec_pkg::count_t written_count;
		logic              string_done;
	} point_beat_t;

	localparam int IdlePct    = 31;
	localparam int QuietLimit = 1000;
	localparam int PhaseBytes = 200;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	u8dec_pkg::count_t cfg_wdata;

	u8dec_in_if  units_if();
	u8dec_out_if points_if();

	utf8_stream_decoder_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.units     (units_if),
		.points    (points_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Mirror of the decoder state and the capacity register
	u8dec_pkg::cp_t    gathered;
	u8dec_pkg::pend_t  awaiting;
	u8dec_pkg::count_t emitted;
	u8dec_pkg::count_t capacity;

	point_beat_t expected_points[$];
	int errors       = 0;
	int quiet_cycles = 0;
	bit steady       = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decode one accepted byte and queue the beat it should produce, if any.
	function automatic void decode_byte(u8dec_pkg::unit_t b, logic last);
		logic           finished;
		logic           written;
		u8dec_pkg::cp_t cp;
		int             shift;
		point_beat_t    beat;
		finished = 1'b0;
		written  = 1'b0;
		cp       = '0;
		if (awaiting == u8dec_pkg::PendNone) begin
			if (b < u8dec_pkg::LeadTwo) begin
				gathered = u8dec_pkg::cp_t'(b);
				finished = 1'b1;
			end else if (b < u8dec_pkg::LeadThree) begin
				// stray continuation bytes land here as two-byte leads
				gathered = u8dec_pkg::cp_t'(b & u8dec_pkg::MaskTwo) << 6;
				awaiting = u8dec_pkg::PendOne;
			end else if (b < u8dec_pkg::LeadFour) begin
				gathered = u8dec_pkg::cp_t'(b & u8dec_pkg::MaskThree) << 12;
				awaiting = u8dec_pkg::PendTwo;
			end else begin
				gathered = u8dec_pkg::cp_t'(b & u8dec_pkg::MaskFour) << 18;
				awaiting = u8dec_pkg::PendThree;
			end
		end else begin
			shift    = 6 * (int'(awaiting) - 1);
			gathered = gathered | (u8dec_pkg::cp_t'(b & u8dec_pkg::MaskCont) << shift);
			awaiting = awaiting - u8dec_pkg::pend_t'(1);
			if (awaiting == u8dec_pkg::PendNone)
				finished = 1'b1;
		end
		// A cut-off sequence at string end completes with zero bits
		if (last && awaiting != u8dec_pkg::PendNone) begin
			awaiting = u8dec_pkg::PendNone;
			finished = 1'b1;
		end
		if (finished) begin
			if (emitted < capacity) begin
				emitted = emitted + u8dec_pkg::count_t'(1);
				cp      = gathered;
				written = 1'b1;
			end
			gathered = '0;
		end
		if (written || last) begin
			beat.decoded       = written ? cp : '0;
			beat.point_valid   = written;
			beat.written_count = emitted;
			beat.string_done   = last;
			expected_points.push_back(beat);
		end
		if (last) begin
			gathered = '0;
			awaiting = u8dec_pkg::PendNone;
			emitted  = '0;
		end
	endfunction

	// Sample both channels at the rising edge: predict on input beats, check
	// output beats against the oldest expectation, and watch for a hang.
	always @(posedge clk) begin
		point_beat_t want;
		if (arst_n) begin
			if (units_if.valid && units_if.ready)
				decode_byte(units_if.in_byte, units_if.string_end);
			if (points_if.valid && points_if.ready) begin
				if (expected_points.size() == 0) begin
					$error("unexpected beat: decoded %h written_count %0d string_done %b",
						points_if.decoded, points_if.written_count, points_if.string_done);
					errors++;
				end else begin
					want = expected_points.pop_front();
					if (points_if.decoded !== want.decoded) begin
						$error("decoded: expected %h, got %h",
							want.decoded, points_if.decoded);
						errors++;
					end
					if (points_if.point_valid !== want.point_valid) begin
						$error("point_valid: expected %b, got %b",
							want.point_valid, points_if.point_valid);
						errors++;
					end
					if (points_if.written_count !== want.written_count) begin
						$error("written_count: expected %0d, got %0d",
							want.written_count, points_if.written_count);
						errors++;
					end
					if (points_if.string_done !== want.string_done) begin
						$error("string_done: expected %b, got %b",
							want.string_done, points_if.string_done);
						errors++;
					end
				end
			end
			if ((units_if.valid && units_if.ready) || (points_if.valid && points_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$error("no beat moved for %0d cycles", QuietLimit);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Stall the result channel at random unless a steady stretch is running
	always @(negedge clk)
		points_if.ready <= steady || ($urandom_range(99) >= IdlePct);

	// Drive one byte, idling first at random, and hold it until accepted.
	// Valid stays high on return so back-to-back beats need no re-raise.
	task automatic send_byte(u8dec_pkg::unit_t b, logic last);
		while (!steady && $urandom_range(99) < IdlePct) begin
			units_if.valid <= 1'b0;
			@(negedge clk);
		end
		units_if.valid      <= 1'b1;
		units_if.in_byte    <= b;
		units_if.string_end <= last;
		do
			@(posedge clk);
		while (!units_if.ready);
		@(negedge clk);
	endtask

	task automatic send_string(u8dec_pkg::unit_t bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic hold_input();
		units_if.valid <= 1'b0;
	endtask

	// Drain every pending beat, let the pipeline settle, then load capacity
	task automatic set_capacity(u8dec_pkg::count_t cap);
		hold_input();
		while (expected_points.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		capacity = cap;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_single_byte();
		send_string('{8'h00, 8'h7F});
	endtask

	// Stray continuation lead, the lowest two-byte sequence, and the highest
	// three- and four-byte sequences
	task automatic test_multi_byte();
		send_string('{8'h80, 8'hBF, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
			8'hFF, 8'hBF, 8'hBF, 8'hBF});
	endtask

	// Sequences cut off by the end of the string
	task automatic test_cut_off();
		send_string('{8'hE2, 8'h82});
		send_string('{8'hF4});
	endtask

	task automatic test_capacity();
		// zero: only the final beat, even for a cut-off sequence
		set_capacity('0);
		send_string('{8'h41, 8'hE1});
		// one: first point kept, the rest dropped silently
		set_capacity(u8dec_pkg::count_t'(1));
		send_string('{8'h41, 8'h42, 8'h43});
	endtask

	function automatic u8dec_pkg::unit_t cont_byte();
		return u8dec_pkg::unit_t'(8'h80 | $urandom_range(8'h3F));
	endfunction

	// Build one string: mostly correctly structured sequences with random payload,
	// sometimes raw noise, sometimes truncated before its end.
	task automatic send_random_string(output int sent);
		u8dec_pkg::unit_t bytes[$];
		int               points;
		int               len;
		points = $urandom_range(1, 12);
		if ($urandom_range(99) < 80) begin
			repeat (points) begin
				len = $urandom_range(1, 4);
				case (len)
					1: bytes.push_back(u8dec_pkg::unit_t'($urandom_range(8'h7F)));
					2: bytes.push_back(($urandom_range(9) == 0) ? cont_byte()
						: u8dec_pkg::unit_t'(8'hC0 | $urandom_range(8'h1F)));
					3: bytes.push_back(u8dec_pkg::unit_t'(8'hE0 | $urandom_range(8'h0F)));
					default: bytes.push_back(u8dec_pkg::unit_t'(8'hF0 | $urandom_range(8'h0F)));
				endcase
				repeat (len - 1) bytes.push_back(cont_byte());
			end
			// drop the tail to leave a sequence open at string end
			if ($urandom_range(9) == 0 && bytes.size() > 1)
				void'(bytes.pop_back());
		end else begin
			repeat ($urandom_range(1, 8))
				bytes.push_back(u8dec_pkg::unit_t'($urandom_range(255)));
		end
		send_string(bytes);
		sent = bytes.size();
	endtask

	task automatic test_random();
		int sent;
		int total;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_capacity(u8dec_pkg::CapReset);
				1: set_capacity('0);
				2: set_capacity(u8dec_pkg::count_t'(1));
				3: set_capacity(u8dec_pkg::count_t'($urandom_range(2, 6)));
				4: set_capacity(u8dec_pkg::count_t'($urandom_range(16'hFFFF)));
				default: set_capacity(u8dec_pkg::CapReset);
			endcase
			// last phase runs with no idling on either side
			steady = (phase == 5);
			total  = 0;
			while (total < PhaseBytes) begin
				send_random_string(sent);
				total += sent;
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		units_if.valid      = 1'b0;
		units_if.in_byte    = '0;
		units_if.string_end = 1'b0;
		points_if.ready     = 1'b0;
		gathered            = '0;
		awaiting            = u8dec_pkg::PendNone;
		emitted             = '0;
		capacity            = u8dec_pkg::CapReset;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_single_byte();
		test_multi_byte();
		test_cut_off();
		test_capacity();
		test_random();

		hold_input();
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
